/* rtl/core/mp3ts_pkg.sv */
package mp3ts_pkg;

	// Status codes carried by a report
	localparam logic [2:0] ST_SYNC_FOUND = 3'd0;
	localparam logic [2:0] ST_TAG_BAD    = 3'd1;
	localparam logic [2:0] ST_LIMIT      = 3'd2;
	localparam logic [2:0] ST_NO_SYNC    = 3'd3;
	localparam logic [2:0] ST_STREAM_END = 3'd4;

	// Result kinds
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Input op codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [15:0] LIMIT_RESET = 16'd2048;

	// Commands passed from the front to the back
	typedef enum logic [1:0] {
		CMD_REPORT,
		CMD_SYNC,
		CMD_FWD
	} cmd_code_t;

	typedef struct packed {
		logic       op;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  out_byte;
		logic [2:0]  status;
		logic        id3_seen;
		logic        album_seen;
		logic [15:0] skipped_count;
		logic        frame_start;
		logic        last;
	} out_item_t;

	// One queued command: a report, a sync (report plus window bytes) or one byte
	typedef struct packed {
		cmd_code_t   code;
		logic [31:0] data;
		logic [2:0]  status;
		logic        id3_seen;
		logic        album_seen;
		logic [15:0] count;
		logic        last;
	} cmd_t;

endpackage

/* rtl/core/mp3ts_fifo.sv */
module mp3ts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/core/mp3ts_front.sv */
module mp3ts_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  mp3ts_pkg::in_item_t  in_data,
	input  logic [15:0]          limit,
	output logic                 push,
	output mp3ts_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		PH_HDR,
		PH_ID3HDR,
		PH_ID3SKIP,
		PH_ALBLEN,
		PH_ALBSKIP,
		PH_SCAN,
		PH_FWD,
		PH_DONE
	} phase_t;

	// Check a 4-byte window for a valid MPEG audio frame header
	function automatic logic hdr_ok(input logic [31:0] w);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [3:0] bad;
		logic       ok;
		b0 = w[31:24];
		b1 = w[23:16];
		b2 = w[15:8];
		b3 = w[7:0];
		case (b2[7:4])
			4'd1, 4'd2, 4'd3, 4'd5:          bad = 4'b0111;
			4'd11, 4'd12, 4'd13, 4'd14, 4'd15: bad = 4'b1000;
			default:                          bad = 4'b0000;
		endcase
		ok = (b0 == 8'hFF) && (b1[7:5] == 3'b111) && (b1[4:3] != 2'b01) &&
			(b1[2:1] != 2'b00) && (b2[7:4] != 4'hF) && (b2[3:2] != 2'b11) &&
			(b3[1:0] != 2'b10);
		// Layer II, MPEG-1: reject disallowed bitrate/mode pairs
		if ((b1[4:3] == 2'b11) && (b1[2:1] == 2'b10) && bad[b3[7:6]]) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	phase_t       phase_q, phase_n;
	logic [2:0]   hcount_q, hcount_n;
	logic [27:0]  tag_q, tag_n;
	logic [31:0]  window_q, window_n;
	logic [2:0]   fill_q, fill_n;
	logic [15:0]  discard_q, discard_n;
	logic [1:0]   seen_q, seen_n;

	logic         accept;
	logic [31:0]  w_shift;
	logic [2:0]   fill_inc;
	logic [15:0]  disc_inc;
	logic [2:0]   hc_inc;
	logic [27:0]  tag_id3;
	logic [27:0]  tag_dec;
	logic [27:0]  alb_len;
	logic         do_scan;

	assign accept   = in_valid && !in_stall;
	assign w_shift  = {window_q[23:0], in_data.in_byte};
	assign fill_inc = fill_q + 3'd1;
	assign disc_inc = discard_q + 16'd1;
	assign hc_inc   = hcount_q + 3'd1;
	assign tag_id3  = (hcount_q >= 3'd2) ? {tag_q[20:0], in_data.in_byte[6:0]} : tag_q;
	assign tag_dec  = (tag_q != '0) ? tag_q - 28'd1 : tag_q;
	assign alb_len  = {12'd0, in_data.in_byte, tag_q[7:0]};

	// Step the stream parser for one accepted transaction
	always_comb begin
		phase_n   = phase_q;
		hcount_n  = hcount_q;
		tag_n     = tag_q;
		window_n  = window_q;
		fill_n    = fill_q;
		discard_n = discard_q;
		seen_n    = seen_q;
		push      = 1'b0;
		do_scan   = 1'b0;
		cmd       = '0;
		cmd.code       = mp3ts_pkg::CMD_REPORT;
		cmd.id3_seen   = seen_q[0];
		cmd.album_seen = seen_q[1];
		cmd.count      = discard_q;

		if (accept) begin
			if (in_data.op == mp3ts_pkg::OP_END) begin
				cmd.last = 1'b1;
				case (phase_q)
					PH_FWD: begin
						push       = 1'b1;
						cmd.status = mp3ts_pkg::ST_STREAM_END;
					end
					PH_HDR, PH_SCAN: begin
						push       = 1'b1;
						cmd.status = mp3ts_pkg::ST_NO_SYNC;
					end
					PH_DONE: push = 1'b0;
					default: begin
						push       = 1'b1;
						cmd.status = mp3ts_pkg::ST_TAG_BAD;
					end
				endcase
				phase_n   = PH_HDR;
				hcount_n  = '0;
				tag_n     = '0;
				window_n  = '0;
				fill_n    = '0;
				discard_n = '0;
				seen_n    = '0;
			end else begin
				case (phase_q)
					PH_HDR: begin
						window_n = w_shift;
						fill_n   = fill_inc;
						if (fill_inc >= 3'd4) begin
							if (seen_q == 2'b00 && w_shift[31:8] == 24'h494433) begin
								phase_n  = PH_ID3HDR;
								hcount_n = '0;
								tag_n    = '0;
							end else if (!seen_q[1] && w_shift == 32'h41694401) begin
								phase_n  = PH_ALBLEN;
								hcount_n = '0;
								tag_n    = '0;
							end else begin
								phase_n = PH_SCAN;
								do_scan = 1'b1;
							end
						end
					end
					PH_SCAN: begin
						window_n = w_shift;
						fill_n   = fill_inc;
						if (fill_inc >= 3'd4) begin
							do_scan = 1'b1;
						end
					end
					PH_ID3HDR: begin
						tag_n    = tag_id3;
						hcount_n = hc_inc;
						if (hc_inc >= 3'd6) begin
							seen_n   = seen_q | 2'b01;
							window_n = '0;
							fill_n   = '0;
							phase_n  = (tag_id3 == '0) ? PH_HDR : PH_ID3SKIP;
						end
					end
					PH_ID3SKIP, PH_ALBSKIP: begin
						tag_n = tag_dec;
						if (tag_dec == '0) begin
							window_n = '0;
							fill_n   = '0;
							phase_n  = PH_HDR;
						end
					end
					PH_ALBLEN: begin
						if (hcount_q == '0) begin
							tag_n    = {20'd0, in_data.in_byte};
							hcount_n = 3'd1;
						end else begin
							seen_n = seen_q | 2'b10;
							if (alb_len < 28'd6) begin
								push           = 1'b1;
								cmd.status     = mp3ts_pkg::ST_TAG_BAD;
								cmd.album_seen = 1'b1;
								cmd.last       = 1'b1;
								tag_n          = alb_len;
								phase_n        = PH_DONE;
							end else begin
								tag_n    = alb_len - 28'd6;
								window_n = '0;
								fill_n   = '0;
								phase_n  = (alb_len == 28'd6) ? PH_HDR : PH_ALBSKIP;
							end
						end
					end
					PH_FWD: begin
						push      = 1'b1;
						cmd.code  = mp3ts_pkg::CMD_FWD;
						cmd.data  = {24'd0, in_data.in_byte};
					end
					default: push = 1'b0;
				endcase

				// Full window: report sync, or drop the oldest byte and report the limit once the discard count reaches it
				if (do_scan) begin
					if (hdr_ok(w_shift)) begin
						push       = 1'b1;
						cmd.code   = mp3ts_pkg::CMD_SYNC;
						cmd.data   = w_shift;
						cmd.status = mp3ts_pkg::ST_SYNC_FOUND;
						phase_n    = PH_FWD;
					end else begin
						window_n  = {8'd0, w_shift[23:0]};
						fill_n    = 3'd3;
						discard_n = disc_inc;
						if (disc_inc >= limit) begin
							push       = 1'b1;
							cmd.status = mp3ts_pkg::ST_LIMIT;
							cmd.count  = disc_inc;
							cmd.last   = 1'b1;
							phase_n    = PH_DONE;
						end
					end
				end
			end
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			hcount_q  <= '0;
			tag_q     <= '0;
			window_q  <= '0;
			fill_q    <= '0;
			discard_q <= '0;
			seen_q    <= '0;
		end else begin
			phase_q   <= phase_n;
			hcount_q  <= hcount_n;
			tag_q     <= tag_n;
			window_q  <= window_n;
			fill_q    <= fill_n;
			discard_q <= discard_n;
			seen_q    <= seen_n;
		end
	end

endmodule

/* rtl/core/mp3ts_back.sv */
module mp3ts_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  mp3ts_pkg::cmd_t      q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mp3ts_pkg::out_item_t out_data
);

	mp3ts_pkg::cmd_t     cur_q;
	logic                cur_valid_q;
	logic [2:0]          sub_q;
	mp3ts_pkg::out_item_t out_q;
	logic                out_valid_q;

	mp3ts_pkg::out_item_t res;
	logic                out_free;
	logic                emit;
	logic                final_piece;

	assign out_free    = !out_valid_q || !out_stall;
	assign emit        = cur_valid_q && out_free;
	assign final_piece = (cur_q.code != mp3ts_pkg::CMD_SYNC) || (sub_q == 3'd4);
	assign q_pop       = !q_empty && (!cur_valid_q || (emit && final_piece));
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;

	// Build the next result transaction from the current command
	always_comb begin
		res = '0;
		case (cur_q.code)
			mp3ts_pkg::CMD_FWD: begin
				res.kind     = mp3ts_pkg::KIND_BYTE;
				res.out_byte = cur_q.data[7:0];
			end
			mp3ts_pkg::CMD_SYNC: begin
				if (sub_q == 3'd0) begin
					res.kind          = mp3ts_pkg::KIND_REPORT;
					res.status        = mp3ts_pkg::ST_SYNC_FOUND;
					res.id3_seen      = cur_q.id3_seen;
					res.album_seen    = cur_q.album_seen;
					res.skipped_count = cur_q.count;
				end else begin
					res.kind        = mp3ts_pkg::KIND_BYTE;
					res.out_byte    = cur_q.data[8 * (3'd4 - sub_q) +: 8];
					res.frame_start = (sub_q == 3'd1);
				end
			end
			default: begin
				res.kind          = mp3ts_pkg::KIND_REPORT;
				res.status        = cur_q.status;
				res.id3_seen      = cur_q.id3_seen;
				res.album_seen    = cur_q.album_seen;
				res.skipped_count = cur_q.count;
				res.last          = cur_q.last;
			end
		endcase
	end

	// Hold the current command and step through its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				sub_q       <= '0;
			end else if (emit) begin
				if (final_piece) begin
					cur_valid_q <= 1'b0;
					sub_q       <= '0;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// Load payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

/* rtl/core/mp3_tag_skip_sync_finder_core.sv */
// Each accepted byte's command goes through the command queue and the current-command register;
// its first result is then held in the output register. Throughput: one input byte per cycle
// while the queue is not full; a sync command yields five results (report plus four window
// bytes), so the four-entry command queue can fill and the input then stalls until an entry frees.
// Reset (arst_n low, asynchronous): parser back to waiting for header bytes, queue and output
// emptied, search limit set to 2048.
module mp3_tag_skip_sync_finder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mp3ts_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mp3ts_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata
);

	localparam int CMD_W = $bits(mp3ts_pkg::cmd_t);

	logic [15:0]     limit_q;
	logic            push;
	mp3ts_pkg::cmd_t cmd;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	logic [CMD_W-1:0] q_rdata;
	mp3ts_pkg::cmd_t q_head;

	assign in_stall = q_full;
	assign q_head   = mp3ts_pkg::cmd_t'(q_rdata);

	// Hold the search limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mp3ts_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	mp3ts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.limit    (limit_q),
		.push     (push),
		.cmd      (cmd)
	);

	mp3ts_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	mp3ts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
